### hw/rtl/colb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colb_pkg
// Shared types and defaults for the cursor ordered list buffer.
// ----------------------------------------------------------------------------
package colb_pkg;

  localparam int DEF_CAPACITY    = 32;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START   = 3'd0,
    ACT_ADVANCE = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_ATTACH  = 3'd3,
    ACT_REMOVE  = 3'd4,
    ACT_READ    = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NO_CURRENT = 2'd2
  } status_t;

  // per-cell command: keep, take new value, take from lower or upper neighbor
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_UP   = 2'd2,
    CELL_DOWN = 2'd3
  } cell_op_t;

endpackage

### hw/rtl/cursor_ordered_list_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_ordered_list_buffer
// Ordered list of up to CAPACITY values with a cursor, held in a row of cells.
// ----------------------------------------------------------------------------
// Path: an input beat first updates the cells, then the slot under the cursor is
//   read and registered into the output register once that register is free.
// Pacing: s_tready stays low from a taken beat until its result is captured.
//   A new beat is taken while the previous result waits on the output.
// Reset: rst (sync, active high) empties the list and clears the cursor and
//   both handshakes; slot contents are not cleared and are never read unset.
// ----------------------------------------------------------------------------
module cursor_ordered_list_buffer #(
  parameter int CAPACITY    = colb_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = colb_pkg::DEF_VALUE_WIDTH,
  localparam int CW    = $clog2(CAPACITY + 1),           // count / cursor
  localparam int IN_W  = ((colb_pkg::ACTION_W + VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((colb_pkg::STATUS_W + CW + 1 + VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // [2:0] action, [VALUE_WIDTH+2:3] entry_value, rest zero
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // [1:0] status, [CW+1:2] item_total, [CW+2] has_current,
  // [CW+VALUE_WIDTH+2:CW+3] current_value, rest zero
  output logic [OUT_W-1:0] m_tdata
);

  localparam int IW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ST_LO  = 0;
  localparam int TOT_LO = colb_pkg::STATUS_W;
  localparam int HAS_B  = TOT_LO + CW;
  localparam int VAL_LO = HAS_B + 1;

  // control state
  logic                busy;       // beat taken, result not yet captured
  logic [CW-1:0]       count;
  logic [CW-1:0]       cursor;
  colb_pkg::status_t   status;

  logic [CW-1:0]       count_next;
  logic [CW-1:0]       cursor_next;
  colb_pkg::status_t   status_next;

  logic                s_fire;
  logic                capture;
  colb_pkg::action_t   act;
  logic [VALUE_WIDTH-1:0] in_val;
  logic                cur_valid;
  logic                full;
  logic                ins_en;     // insert or attach that goes ahead
  logic                rem_en;     // remove that goes ahead
  logic [CW-1:0]       pos;        // slot that receives the new value

  logic [VALUE_WIDTH-1:0] cell_q [CAPACITY];
  colb_pkg::cell_op_t     cell_op [CAPACITY];
  logic [OUT_W-1:0]       out_word;
  logic                   has_cur;

  assign s_tready = !busy;
  assign s_fire   = s_tvalid && s_tready;
  assign capture  = busy && (!m_tvalid || m_tready);

  assign act       = colb_pkg::action_t'(s_tdata[colb_pkg::ACTION_W-1:0]);
  assign in_val    = s_tdata[colb_pkg::ACTION_W +: VALUE_WIDTH];
  assign cur_valid = cursor < count;
  assign full      = count == CW'(CAPACITY);

  // list operation decode
  always_comb begin
    count_next  = count;
    cursor_next = cursor;
    status_next = colb_pkg::ST_OK;
    ins_en      = 1'b0;
    rem_en      = 1'b0;
    pos         = '0;
    unique case (act)
      colb_pkg::ACT_START: begin
        cursor_next = '0;
      end
      colb_pkg::ACT_ADVANCE: begin
        cursor_next = cur_valid ? cursor + CW'(1) : count;
      end
      colb_pkg::ACT_INSERT: begin
        if (full) begin
          status_next = colb_pkg::ST_FULL;
        end else begin
          ins_en      = 1'b1;
          pos         = cur_valid ? cursor : '0;
          cursor_next = pos;
          count_next  = count + CW'(1);
        end
      end
      colb_pkg::ACT_ATTACH: begin
        if (full) begin
          status_next = colb_pkg::ST_FULL;
        end else begin
          ins_en      = 1'b1;
          pos         = cur_valid ? cursor + CW'(1) : count;
          cursor_next = pos;
          count_next  = count + CW'(1);
        end
      end
      colb_pkg::ACT_REMOVE: begin
        if (!cur_valid) begin
          status_next = colb_pkg::ST_NO_CURRENT;
        end else begin
          rem_en     = 1'b1;
          count_next = count - CW'(1);
        end
      end
      default: begin
        // read only, and unused codes
      end
    endcase
  end

  // row of cells; each one decides its move from its own index
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic [VALUE_WIDTH-1:0] lower_v;
    logic [VALUE_WIDTH-1:0] upper_v;

    if (i == 0) begin : g_first
      assign lower_v = cell_q[i];
    end else begin : g_mid_lo
      assign lower_v = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper_v = cell_q[i];
    end else begin : g_mid_hi
      assign upper_v = cell_q[i+1];
    end

    always_comb begin
      cell_op[i] = colb_pkg::CELL_HOLD;
      if (s_fire && ins_en) begin
        if (IDX > pos)       cell_op[i] = colb_pkg::CELL_UP;
        else if (IDX == pos) cell_op[i] = colb_pkg::CELL_LOAD;
      end else if (s_fire && rem_en) begin
        if (IDX >= cursor)   cell_op[i] = colb_pkg::CELL_DOWN;
      end
    end

    colb_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .op        (cell_op[i]),
      .load_val  (in_val),
      .lower_val (lower_v),
      .upper_val (upper_v),
      .val       (cell_q[i])
    );
  end

  // result word from the settled cells
  assign has_cur = cursor < count;
  always_comb begin
    out_word = '0;
    out_word[ST_LO +: colb_pkg::STATUS_W] = status;
    out_word[TOT_LO +: CW]                = count;
    out_word[HAS_B]                       = has_cur;
    out_word[VAL_LO +: VALUE_WIDTH]       = has_cur ? cell_q[cursor[IW-1:0]] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      count    <= '0;
      cursor   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_fire) begin
        busy   <= 1'b1;
        count  <= count_next;
        cursor <= cursor_next;
        status <= status_next;
      end
      if (capture) begin
        busy     <= 1'b0;
        m_tvalid <= 1'b1;
        m_tdata  <= out_word;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/colb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colb_cell
// One list slot: holds a value, loads a new one or takes a neighbor's.
// ----------------------------------------------------------------------------
module colb_cell #(
  parameter int VALUE_WIDTH = colb_pkg::DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  colb_pkg::cell_op_t     op,
  input  logic [VALUE_WIDTH-1:0] load_val,
  input  logic [VALUE_WIDTH-1:0] lower_val,  // from slot i-1
  input  logic [VALUE_WIDTH-1:0] upper_val,  // from slot i+1
  output logic [VALUE_WIDTH-1:0] val
);

  always_ff @(posedge clk) begin
    unique case (op)
      colb_pkg::CELL_LOAD: val <= load_val;
      colb_pkg::CELL_UP:   val <= lower_val;
      colb_pkg::CELL_DOWN: val <= upper_val;
      default:             val <= val;
    endcase
  end

endmodule

### hw/rtl/colb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colb_checker
// Port-level checks for the cursor ordered list buffer, bound to the top.
// ----------------------------------------------------------------------------
module colb_checker #(
  parameter int CAPACITY    = colb_pkg::DEF_CAPACITY,
  parameter int VALUE_WIDTH = colb_pkg::DEF_VALUE_WIDTH,
  localparam int CW    = $clog2(CAPACITY + 1),
  localparam int OUT_W = ((colb_pkg::STATUS_W + CW + 1 + VALUE_WIDTH + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  localparam int TOT_LO = colb_pkg::STATUS_W;
  localparam int HAS_B  = TOT_LO + CW;
  localparam int VAL_LO = HAS_B + 1;

  logic [colb_pkg::STATUS_W-1:0] o_status;
  logic [CW-1:0]                 o_total;
  logic                          o_has;
  logic [VALUE_WIDTH-1:0]        o_value;
  logic                          s_fire;

  assign o_status = m_tdata[colb_pkg::STATUS_W-1:0];
  assign o_total  = m_tdata[TOT_LO +: CW];
  assign o_has    = m_tdata[HAS_B];
  assign o_value  = m_tdata[VAL_LO +: VALUE_WIDTH];
  assign s_fire   = s_tvalid && s_tready;

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> o_total <= CW'(CAPACITY))
    else $error("item_total above capacity");

  a_no_cur_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !o_has) |-> o_value == '0)
    else $error("current_value nonzero without current item");

  a_full_total: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_status == colb_pkg::ST_FULL) |-> o_total == CW'(CAPACITY))
    else $error("full status on a list that is not full");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> !s_tready)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

endmodule

bind cursor_ordered_list_buffer colb_checker #(
  .CAPACITY    (CAPACITY),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_colb_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
